@@ rtl/asd_pkg.sv @@
// Shared types, codes and the magic table of the archive stream deframer.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps
`default_nettype none

package asd_pkg;

	// Input beat: one archive byte plus the end-of-archive mark
	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_input;
	} asd_in_t;

	// Output beat: the byte, its tag and the status after it
	typedef struct packed {
		logic [7:0]  byte_value;
		logic [2:0]  byte_kind;
		logic [31:0] file_number;
		logic        field_last;
		logic [2:0]  parse_status;
	} asd_out_t;

	// Parser phases
	localparam logic [2:0] PH_MAGIC   = 3'd0;
	localparam logic [2:0] PH_VERSION = 3'd1;
	localparam logic [2:0] PH_COUNT   = 3'd2;
	localparam logic [2:0] PH_NAMELEN = 3'd3;
	localparam logic [2:0] PH_NAME    = 3'd4;
	localparam logic [2:0] PH_SIZE    = 3'd5;
	localparam logic [2:0] PH_CONTENT = 3'd6;
	localparam logic [2:0] PH_HALT    = 3'd7;

	// Byte kinds
	localparam logic [2:0] K_MAGIC   = 3'd0;
	localparam logic [2:0] K_VERSION = 3'd1;
	localparam logic [2:0] K_COUNT   = 3'd2;
	localparam logic [2:0] K_NAMELEN = 3'd3;
	localparam logic [2:0] K_NAME    = 3'd4;
	localparam logic [2:0] K_SIZE    = 3'd5;
	localparam logic [2:0] K_CONTENT = 3'd6;
	localparam logic [2:0] K_IGNORED = 3'd7;

	// Parse status
	localparam logic [2:0] ST_RUNNING  = 3'd0;
	localparam logic [2:0] ST_COMPLETE = 3'd1;
	localparam logic [2:0] ST_BADMAGIC = 3'd2;
	localparam logic [2:0] ST_BADVER   = 3'd3;
	localparam logic [2:0] ST_TRUNC    = 3'd4;

	localparam logic [7:0] VERSION_RESET = 8'h01;

	// Expected magic byte at a given position of the header
	function automatic logic [7:0] magic_byte(input logic [1:0] idx);
		logic [7:0] m;
		case (idx)
			2'd0: m = 8'h56;
			2'd1: m = 8'h59;
			2'd2: m = 8'h54;
			default: m = 8'h52;
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

@@ rtl/asd_parse.sv @@
// Parser state and per-byte tagging logic of the archive stream deframer.
// Depends on asd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module asd_parse
	import asd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire asd_in_t    item,
	input  wire logic [7:0] expected_version,
	output asd_out_t        result
);

	logic [2:0]  phase_q, phase_d;
	logic [1:0]  fbc_q, fbc_d;
	logic [31:0] asm_q, asm_d;
	logic [31:0] files_q, files_d;
	logic [31:0] cur_q, cur_d;
	logic [15:0] name_q, name_d;
	logic [31:0] cont_q, cont_d;
	logic [2:0]  status_q, status_d;

	logic [31:0] asm_new;
	logic [31:0] files_dec;
	logic [15:0] name_dec;
	logic [31:0] cont_dec;
	logic [2:0]  kind;
	logic [31:0] fnum;
	logic        last;
	logic [7:0]  b;

	always_comb begin
		b         = item.data_byte;
		asm_new   = asm_q | ({24'd0, b} << {fbc_q, 3'b000});
		files_dec = files_q - 32'd1;
		name_dec  = name_q - 16'd1;
		cont_dec  = cont_q - 32'd1;

		phase_d  = phase_q;
		fbc_d    = fbc_q;
		asm_d    = asm_q;
		files_d  = files_q;
		cur_d    = cur_q;
		name_d   = name_q;
		cont_d   = cont_q;
		status_d = status_q;
		kind     = K_IGNORED;
		fnum     = 32'd0;
		last     = 1'b0;

		case (phase_q)
			PH_MAGIC: begin
				kind = K_MAGIC;
				last = (fbc_q == 2'd3);
				if (b != magic_byte(fbc_q)) begin
					phase_d  = PH_HALT;
					status_d = ST_BADMAGIC;
				end else if (last) begin
					fbc_d   = 2'd0;
					phase_d = PH_VERSION;
				end else begin
					fbc_d = fbc_q + 2'd1;
				end
			end
			PH_VERSION: begin
				kind = K_VERSION;
				last = 1'b1;
				if (b != expected_version) begin
					phase_d  = PH_HALT;
					status_d = ST_BADVER;
				end else begin
					fbc_d   = 2'd0;
					asm_d   = 32'd0;
					phase_d = PH_COUNT;
				end
			end
			PH_COUNT: begin
				kind = K_COUNT;
				last = (fbc_q == 2'd3);
				if (last) begin
					files_d = asm_new;
					fbc_d   = 2'd0;
					asm_d   = 32'd0;
					if (asm_new == 32'd0) begin
						phase_d  = PH_HALT;
						status_d = ST_COMPLETE;
					end else begin
						phase_d = PH_NAMELEN;
					end
				end else begin
					asm_d = asm_new;
					fbc_d = fbc_q + 2'd1;
				end
			end
			PH_NAMELEN: begin
				kind = K_NAMELEN;
				fnum = cur_q;
				last = (fbc_q == 2'd1);
				if (last) begin
					name_d  = asm_new[15:0];
					fbc_d   = 2'd0;
					asm_d   = 32'd0;
					phase_d = (asm_new[15:0] == 16'd0) ? PH_SIZE : PH_NAME;
				end else begin
					asm_d = asm_new;
					fbc_d = fbc_q + 2'd1;
				end
			end
			PH_NAME: begin
				kind   = K_NAME;
				fnum   = cur_q;
				name_d = name_dec;
				if (name_dec == 16'd0) begin
					last    = 1'b1;
					fbc_d   = 2'd0;
					asm_d   = 32'd0;
					phase_d = PH_SIZE;
				end
			end
			PH_SIZE: begin
				kind = K_SIZE;
				fnum = cur_q;
				last = (fbc_q == 2'd3);
				if (last) begin
					cont_d = asm_new;
					fbc_d  = 2'd0;
					asm_d  = 32'd0;
					if (asm_new == 32'd0) begin
						// empty content: close the file here
						files_d = files_dec;
						cur_d   = cur_q + 32'd1;
						if (files_dec == 32'd0) begin
							phase_d  = PH_HALT;
							status_d = ST_COMPLETE;
						end else begin
							phase_d = PH_NAMELEN;
						end
					end else begin
						phase_d = PH_CONTENT;
					end
				end else begin
					asm_d = asm_new;
					fbc_d = fbc_q + 2'd1;
				end
			end
			PH_CONTENT: begin
				kind   = K_CONTENT;
				fnum   = cur_q;
				cont_d = cont_dec;
				if (cont_dec == 32'd0) begin
					last    = 1'b1;
					files_d = files_dec;
					cur_d   = cur_q + 32'd1;
					if (files_dec == 32'd0) begin
						phase_d  = PH_HALT;
						status_d = ST_COMPLETE;
					end else begin
						phase_d = PH_NAMELEN;
					end
				end
			end
			default: begin
				// halted: hold everything
			end
		endcase

		// early end while still running
		if (phase_q != PH_HALT && item.end_of_input && status_d == ST_RUNNING) begin
			status_d = ST_TRUNC;
			phase_d  = PH_HALT;
		end

		result.byte_value   = b;
		result.byte_kind    = kind;
		result.file_number  = fnum;
		result.field_last   = last;
		result.parse_status = status_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_MAGIC;
			fbc_q    <= 2'd0;
			asm_q    <= 32'd0;
			files_q  <= 32'd0;
			cur_q    <= 32'd0;
			name_q   <= 16'd0;
			cont_q   <= 32'd0;
			status_q <= ST_RUNNING;
		end else if (step) begin
			phase_q  <= phase_d;
			fbc_q    <= fbc_d;
			asm_q    <= asm_d;
			files_q  <= files_d;
			cur_q    <= cur_d;
			name_q   <= name_d;
			cont_q   <= cont_d;
			status_q <= status_d;
		end
	end

endmodule

`default_nettype wire

@@ rtl/archive_stream_deframer.sv @@
// Top level of the archive stream deframer: handshake, input and result stages.
// Depends on asd_pkg and asd_parse.
`timescale 1ns / 1ps
`default_nettype none

// Archive stream deframer. Feed the archive one byte per beat on the input
// channel and mark the final byte with end_of_input. Every input beat yields
// exactly one output beat carrying the same byte, its field kind (magic,
// version, file count, name length, name, content size, content, or ignored),
// the index of the file it belongs to, a flag on the last byte of each field,
// and the parse status after that byte. The header must start with the magic
// 56 59 54 52 followed by a version byte equal to expected_version (reset 1,
// written through the cfg channel; the user must write it only while the
// block is idle, which the block itself does not enforce; cfg_ready is
// always high). After completion, a bad magic, a bad version or a truncated
// stream, every later byte is tagged ignored with the held status until reset.
// Throughput is one byte per cycle while the output does not stall; the parse
// logic between the input stage and the registered result stage advances once
// per byte. The input stage frees itself whenever the result stage can move,
// so one more byte is taken while a finished result waits on a stalled output.

module archive_stream_deframer
	import asd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire asd_in_t    in_data,
	output logic            out_valid,
	input  wire logic       out_ready,
	output asd_out_t        out_data,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [7:0] cfg_data
);

	logic       v_s1;
	asd_in_t    item_s1;
	logic       v_s2;
	asd_out_t   res_s2;
	logic [7:0] version_q;
	logic       adv_s1;
	logic       step;
	asd_out_t   result;

	// result stage moves when empty or being drained
	assign adv_s1    = !v_s2 || out_ready;
	assign in_ready  = !v_s1 || adv_s1;
	assign step      = v_s1 && adv_s1;
	assign out_valid = v_s2;
	assign out_data  = res_s2;
	assign cfg_ready = 1'b1;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			version_q <= VERSION_RESET;
		end else if (cfg_valid && cfg_ready) begin
			version_q <= cfg_data;
		end
	end

	// input stage: take a beat whenever the stage is free or moving on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	// parse one byte per step
	asd_parse u_parse (
		.clk              (clk),
		.arst_n           (arst_n),
		.step             (step),
		.item             (item_s1),
		.expected_version (version_q),
		.result           (result)
	);

	// result stage: hold while the output stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv_s1) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_s2 <= result;
		end
	end

endmodule

`default_nettype wire

@@ rtl/asd_checker.sv @@
// Port-level checks for the archive stream deframer and the bind that attaches them.
// Depends on asd_pkg and archive_stream_deframer.
`timescale 1ns / 1ps
`default_nettype none

module asd_checker
	import asd_pkg::*;
(
	input wire logic     clk,
	input wire logic     arst_n,
	input wire logic     in_ready,
	input wire logic     out_valid,
	input wire logic     out_ready,
	input wire asd_out_t out_data
);

	logic       done_q;
	logic [2:0] stat_q;

	// remember the first final status seen on the output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			stat_q <= ST_RUNNING;
		end else if (out_valid && out_ready && !done_q &&
			out_data.parse_status != ST_RUNNING) begin
			done_q <= 1'b1;
			stat_q <= out_data.parse_status;
		end
	end

	// stalled output holds its beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output beat changed while stalled");

	// input backs up only behind a full output
	a_in_flow: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with empty output");

	// after a final status every beat is ignored and repeats it
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_q |->
			out_data.byte_kind == K_IGNORED && out_data.parse_status == stat_q &&
			out_data.file_number == 32'd0 && !out_data.field_last)
		else $error("beat after final status not ignored");

	// ignored bytes only appear once parsing has stopped
	a_ignored_final: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.byte_kind == K_IGNORED |->
			out_data.parse_status != ST_RUNNING && done_q)
		else $error("ignored beat while still running");

endmodule

bind archive_stream_deframer asd_checker u_asd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

`default_nettype wire
